### sv/bwu_pkg.sv
package bwu_pkg;

   localparam int MaxEntriesDefault = 16;
   localparam int NumLists = 4;

   typedef enum logic [2:0] {
      OP_BOUNDARY = 3'd0,
      OP_MEM_READ = 3'd1,
      OP_MEM_WRITE = 3'd2,
      OP_IO = 3'd3,
      OP_TOGGLE = 3'd4,
      OP_SET_STEP = 3'd5,
      OP_STOP_REQ = 3'd6,
      OP_UNUSED = 3'd7
   } opcode_type;

   localparam logic [1:0] LIST_BP = 2'd0;
   localparam logic [1:0] LIST_WW = 2'd1;
   localparam logic [1:0] LIST_RW = 2'd2;
   localparam logic [1:0] LIST_PW = 2'd3;

   localparam logic [1:0] KIND_MEM_READ = 2'd0;
   localparam logic [1:0] KIND_MEM_WRITE = 2'd1;
   localparam logic [1:0] KIND_IO_IN = 2'd2;
   localparam logic [1:0] KIND_IO_OUT = 2'd3;

   localparam logic [1:0] TOG_NONE = 2'd0;
   localparam logic [1:0] TOG_ADDED = 2'd1;
   localparam logic [1:0] TOG_REMOVED = 2'd2;
   localparam logic [1:0] TOG_FULL = 2'd3;

   localparam logic [15:0] ShortPortMax = 16'h00ff;

   // command travelling down the row of cells
   typedef struct packed {
      logic       search;     // compare against this list's entries
      logic       port_mode;  // apply short port matching
      logic [15:0] key;
   } cell_cmd_type;

   // cell edit applied in the update cycle
   typedef struct packed {
      logic       write_en;
      logic [15:0] value;
   } cell_edit_type;

endpackage

### sv/bwu_cell.sv
module bwu_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  bwu_pkg::cell_cmd_type cmd,
   input  bwu_pkg::cell_edit_type edit,
   output logic                  match,
   output logic [15:0]           entry
);

   logic [15:0] entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (edit.write_en) begin
         entry_in = edit.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_comb begin
      match = 1'b0;
      if (valid_in && cmd.search) begin
         if (cmd.port_mode && entry_ff <= bwu_pkg::ShortPortMax) begin
            match = (cmd.key[7:0] == entry_ff[7:0]);
         end else begin
            match = (cmd.key == entry_ff);
         end
      end
   end

   assign entry = entry_ff;

   logic unused_reset;
   assign unused_reset = reset;

endmodule

### sv/bwu_list.sv
module bwu_list #(
   parameter int MAX_ENTRIES = bwu_pkg::MaxEntriesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bwu_pkg::cell_cmd_type cmd,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] count,
   input  logic                  rm_en,
   input  logic                  add_en,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] count_after,
   output logic                  hit,
   output logic [$clog2(MAX_ENTRIES+1)-1:0] hit_index
);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [MAX_ENTRIES-1:0] match_v;
   logic [15:0] entries [MAX_ENTRIES];
   logic [15:0] last_entry;
   bwu_pkg::cell_edit_type edits [MAX_ENTRIES];

   always_comb begin
      last_entry = entries[0];
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (CW'(i) == count_after) begin
            last_entry = entries[i];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
         always_comb begin
            edits[g].write_en = 1'b0;
            edits[g].value = cmd.key;
            if (add_en && count == CW'(g)) begin
               edits[g].write_en = 1'b1;
            end
            if (rm_en && hit_index == CW'(g)) begin
               edits[g].write_en = 1'b1;
               edits[g].value = last_entry;
            end
         end
         bwu_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .valid_in (CW'(g) < count),
            .cmd      (cmd),
            .edit     (edits[g]),
            .match    (match_v[g]),
            .entry    (entries[g])
         );
      end
   endgenerate

   always_comb begin
      hit = |match_v;
      hit_index = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_v[i]) begin
            hit_index = CW'(i);
         end
      end
   end

endmodule

### sv/breakpoint_watchpoint_unit.sv
// breakpoint and watchpoint debug unit
// req channel: one item per debug event (instruction boundary, memory or io
// access, list toggle, step load, stop request); rsp channel: one item per
// request item, carrying stop causes, a delivered watch report and the
// toggle status.
// each of the four address lists is a row of cells; every cell compares
// its entry with the item's address in parallel, and toggle edits write
// one cell (append) or move the last entry into a freed cell (remove).
// the result is registered and appears in the cycle after acceptance.
// throughput: one item per cycle while the receiver takes results; the
// single output register lets a new item in whenever it is empty or
// being drained in the same cycle.
// when the receiver stalls, the result holds and req_tready drops.
// reset clears list counts, pending report, stop request, step counter
// and the output valid flag; list contents are undefined until written.
module breakpoint_watchpoint_unit #(
   parameter int MAX_ENTRIES = bwu_pkg::MaxEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], address[18:3], data[26:19], io_out[27], halted[28],
   // list_select[30:29], step_count[46:31], zero pad[47]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // stop[0], breakpoint_hit[1], external_stop[2], step_done[3],
   // watch_fired[4], watch_kind[6:5], watch_address[22:7],
   // watch_data[30:23], toggle_status[32:31], zero pad[39:33]
   output logic [39:0] rsp_tdata
);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   bwu_pkg::opcode_type opcode;
   logic [15:0] address, step_count;
   logic [7:0]  data;
   logic        io_out, halted;
   logic [1:0]  list_select;

   assign opcode      = bwu_pkg::opcode_type'(req_tdata[2:0]);
   assign address     = req_tdata[18:3];
   assign data        = req_tdata[26:19];
   assign io_out      = req_tdata[27];
   assign halted      = req_tdata[28];
   assign list_select = req_tdata[30:29];
   assign step_count  = req_tdata[46:31];

   logic accept;
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept = req_tvalid && req_tready;

   logic [CW-1:0] count_ff [bwu_pkg::NumLists];
   logic [CW-1:0] count_in [bwu_pkg::NumLists];
   logic          pend_valid_ff, pend_valid_in;
   logic [25:0]   pend_ff, pend_in;
   logic          stop_req_ff, stop_req_in;
   logic [15:0]   step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [32:0]   rsp_ff, rsp_in;

   logic [3:0]    hit;
   logic [CW-1:0] hit_index [bwu_pkg::NumLists];
   logic [3:0]    rm_en, add_en;
   logic [CW-1:0] count_after [bwu_pkg::NumLists];
   bwu_pkg::cell_cmd_type cmds [bwu_pkg::NumLists];
   logic          is_toggle;

   assign is_toggle = accept && opcode == bwu_pkg::OP_TOGGLE;

   genvar l;
   generate
      for (l = 0; l < bwu_pkg::NumLists; l++) begin : g_list
         always_comb begin
            cmds[l].key = address;
            cmds[l].port_mode = (l == bwu_pkg::LIST_PW) && opcode != bwu_pkg::OP_TOGGLE;
            cmds[l].search = 1'b1;
            rm_en[l] = is_toggle && list_select == 2'(l) && hit[l];
            add_en[l] = is_toggle && list_select == 2'(l) && !hit[l]
                        && count_ff[l] < CW'(MAX_ENTRIES);
            count_after[l] = count_ff[l] - CW'(1);
         end
         bwu_list #(.MAX_ENTRIES(MAX_ENTRIES)) u_list (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmds[l]),
            .count       (count_ff[l]),
            .rm_en       (rm_en[l]),
            .add_en      (add_en[l]),
            .count_after (count_after[l]),
            .hit         (hit[l]),
            .hit_index   (hit_index[l])
         );
      end
   endgenerate

   always_comb begin
      logic stop, bp, ext, sd, wf;
      logic [1:0] tog;
      logic [25:0] rep;
      stop = 1'b0; bp = 1'b0; ext = 1'b0; sd = 1'b0; wf = 1'b0;
      tog = bwu_pkg::TOG_NONE;
      rep = '0;
      for (int i = 0; i < bwu_pkg::NumLists; i++) begin
         count_in[i] = count_ff[i];
         if (rm_en[i]) count_in[i] = count_after[i];
         if (add_en[i]) count_in[i] = count_ff[i] + CW'(1);
      end
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      stop_req_in = stop_req_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (opcode)
            bwu_pkg::OP_BOUNDARY: begin
               if (!halted && hit[bwu_pkg::LIST_BP]) begin
                  bp = 1'b1;
               end
               if (stop_req_ff) begin
                  ext = 1'b1;
                  stop_req_in = 1'b0;
               end
               if (pend_valid_ff) begin
                  wf = 1'b1;
                  rep = pend_ff;
                  pend_valid_in = 1'b0;
               end
               if (step_ff != 16'd0) begin
                  step_in = step_ff - 16'd1;
                  sd = (step_ff == 16'd1);
               end
               stop = bp || ext || wf || sd;
            end
            bwu_pkg::OP_MEM_READ: begin
               if (!pend_valid_ff && hit[bwu_pkg::LIST_RW]) begin
                  pend_valid_in = 1'b1;
                  pend_in = {bwu_pkg::KIND_MEM_READ, address, data};
               end
            end
            bwu_pkg::OP_MEM_WRITE: begin
               if (!pend_valid_ff && hit[bwu_pkg::LIST_WW]) begin
                  pend_valid_in = 1'b1;
                  pend_in = {bwu_pkg::KIND_MEM_WRITE, address, data};
               end
            end
            bwu_pkg::OP_IO: begin
               if (!pend_valid_ff && hit[bwu_pkg::LIST_PW]) begin
                  pend_valid_in = 1'b1;
                  pend_in = {io_out ? bwu_pkg::KIND_IO_OUT : bwu_pkg::KIND_IO_IN,
                             address, data};
               end
            end
            bwu_pkg::OP_TOGGLE: begin
               if (hit[list_select]) tog = bwu_pkg::TOG_REMOVED;
               else if (count_ff[list_select] >= CW'(MAX_ENTRIES)) tog = bwu_pkg::TOG_FULL;
               else tog = bwu_pkg::TOG_ADDED;
            end
            bwu_pkg::OP_SET_STEP: begin
               step_in = (step_count == 16'd0) ? 16'd1 : step_count;
            end
            bwu_pkg::OP_STOP_REQ: begin
               stop_req_in = 1'b1;
            end
            default: begin
            end
         endcase
         rsp_in = {tog, rep[7:0], rep[23:8], rep[25:24], wf, sd, ext, bp, stop};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bwu_pkg::NumLists; i++) count_ff[i] <= '0;
         pend_valid_ff <= 1'b0;
         pend_ff <= '0;
         stop_req_ff <= 1'b0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
         pend_ff <= pend_in;
         stop_req_ff <= stop_req_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_ff};

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CW'(MAX_ENTRIES) && count_ff[3] <= CW'(MAX_ENTRIES))
      else $error("list count beyond depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_accept_out: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == bwu_pkg::OP_BOUNDARY |=> !pend_valid_ff)
      else $error("pending report survived a boundary");
`endif

endmodule

### sim/breakpoint_watchpoint_unit_tb.sv
module breakpoint_watchpoint_unit_tb;

   typedef struct packed {
      logic [15:0] step_count;
      logic [1:0]  list_select;
      logic        halted;
      logic        io_out;
      logic [7:0]  data;
      logic [15:0] address;
      bwu_pkg::opcode_type opcode;
   } debug_event_type;

   typedef struct packed {
      logic [1:0]  toggle_status;
      logic [7:0]  watch_data;
      logic [15:0] watch_address;
      logic [1:0]  watch_kind;
      logic        watch_fired;
      logic        step_done;
      logic        external_stop;
      logic        breakpoint_hit;
      logic        stop;
   } debug_verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   breakpoint_watchpoint_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state
   logic [15:0] watch_lists [4][16];
   int          list_len [4];
   logic        report_valid;
   logic [1:0]  report_kind;
   logic [15:0] report_addr;
   logic [7:0]  report_data;
   logic        stop_pending;
   logic [15:0] steps_left;

   debug_event_type   pending_events [$];
   debug_verdict_type expected_verdicts [$];
   int errors = 0;
   int verdicts_seen = 0;
   int stops_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_send = 0;

   function automatic logic list_holds(int sel, logic [15:0] v);
      for (int i = 0; i < list_len[sel]; i++)
         if (watch_lists[sel][i] == v) return 1;
      return 0;
   endfunction

   function automatic logic port_hits(logic [15:0] port);
      logic [15:0] w;
      for (int i = 0; i < list_len[bwu_pkg::LIST_PW]; i++) begin
         w = watch_lists[bwu_pkg::LIST_PW][i];
         if (w <= bwu_pkg::ShortPortMax ? (port[7:0] == w[7:0]) : (port == w)) return 1;
      end
      return 0;
   endfunction

   function automatic void latch_report(logic [1:0] k, logic [15:0] a, logic [7:0] d);
      report_valid = 1;
      report_kind = k;
      report_addr = a;
      report_data = d;
   endfunction

   function automatic debug_verdict_type predict_verdict(debug_event_type ev);
      debug_verdict_type r;
      int sel;
      int n;
      r = '0;
      sel = ev.list_select;
      case (ev.opcode)
         bwu_pkg::OP_BOUNDARY: begin
            if (!ev.halted && list_holds(bwu_pkg::LIST_BP, ev.address)) r.breakpoint_hit = 1;
            if (stop_pending) begin
               stop_pending = 0;
               r.external_stop = 1;
            end
            if (report_valid) begin
               r.watch_fired = 1;
               r.watch_kind = report_kind;
               r.watch_address = report_addr;
               r.watch_data = report_data;
               report_valid = 0;
            end
            if (steps_left != 0) begin
               steps_left = steps_left - 16'd1;
               if (steps_left == 0) r.step_done = 1;
            end
            r.stop = r.breakpoint_hit | r.external_stop | r.watch_fired | r.step_done;
         end
         bwu_pkg::OP_MEM_READ:
            if (!report_valid && list_holds(bwu_pkg::LIST_RW, ev.address))
               latch_report(bwu_pkg::KIND_MEM_READ, ev.address, ev.data);
         bwu_pkg::OP_MEM_WRITE:
            if (!report_valid && list_holds(bwu_pkg::LIST_WW, ev.address))
               latch_report(bwu_pkg::KIND_MEM_WRITE, ev.address, ev.data);
         bwu_pkg::OP_IO:
            if (!report_valid && port_hits(ev.address))
               latch_report(ev.io_out ? bwu_pkg::KIND_IO_OUT : bwu_pkg::KIND_IO_IN,
                            ev.address, ev.data);
         bwu_pkg::OP_TOGGLE: begin
            n = list_len[sel];
            r.toggle_status = (n >= bwu_pkg::MaxEntriesDefault) ? bwu_pkg::TOG_FULL
                                                                : bwu_pkg::TOG_ADDED;
            for (int i = 0; i < n; i++)
               if (r.toggle_status != bwu_pkg::TOG_REMOVED &&
                   watch_lists[sel][i] == ev.address) begin
                  list_len[sel] = n - 1;
                  watch_lists[sel][i] = watch_lists[sel][n - 1];
                  r.toggle_status = bwu_pkg::TOG_REMOVED;
               end
            if (r.toggle_status == bwu_pkg::TOG_ADDED) begin
               watch_lists[sel][n] = ev.address;
               list_len[sel] = n + 1;
            end
         end
         bwu_pkg::OP_SET_STEP: steps_left = (ev.step_count == 0) ? 16'd1 : ev.step_count;
         bwu_pkg::OP_STOP_REQ: stop_pending = 1;
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch in %s: got %h, expected %h (result %0d)", what, got, want,
               verdicts_seen);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= {1'b0, pending_events[0]};
               expected_verdicts.push_back(predict_verdict(pending_events.pop_front()));
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      debug_verdict_type got;
      debug_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[32:0];
         verdicts_seen++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected result", 32'(got), 32'd0);
         end else begin
            want = expected_verdicts.pop_front();
            if (got.stop) stops_seen++;
            if (got.stop != want.stop)
               report_mismatch("stop", 32'(got.stop), 32'(want.stop));
            if (got.breakpoint_hit != want.breakpoint_hit)
               report_mismatch("breakpoint_hit", 32'(got.breakpoint_hit),
                               32'(want.breakpoint_hit));
            if (got.external_stop != want.external_stop)
               report_mismatch("external_stop", 32'(got.external_stop),
                               32'(want.external_stop));
            if (got.step_done != want.step_done)
               report_mismatch("step_done", 32'(got.step_done), 32'(want.step_done));
            if (got.watch_fired != want.watch_fired)
               report_mismatch("watch_fired", 32'(got.watch_fired), 32'(want.watch_fired));
            if (got.watch_kind != want.watch_kind)
               report_mismatch("watch_kind", 32'(got.watch_kind), 32'(want.watch_kind));
            if (got.watch_address != want.watch_address)
               report_mismatch("watch_address", 32'(got.watch_address),
                               32'(want.watch_address));
            if (got.watch_data != want.watch_data)
               report_mismatch("watch_data", 32'(got.watch_data), 32'(want.watch_data));
            if (got.toggle_status != want.toggle_status)
               report_mismatch("toggle_status", 32'(got.toggle_status),
                               32'(want.toggle_status));
            if (rsp_tdata[39:33] != 0)
               report_mismatch("pad", 32'(rsp_tdata[39:33]), 32'd0);
         end
      end
   end

   function automatic debug_event_type make_event(bwu_pkg::opcode_type op, logic [15:0] a);
      debug_event_type e;
      e.opcode = op;
      e.address = a;
      e.data = 8'($urandom);
      e.io_out = 1'($urandom);
      e.halted = 0;
      e.list_select = 2'($urandom);
      e.step_count = 16'($urandom);
      return e;
   endfunction

   // addresses drawn from a small pool so that lists and watches hit often
   function automatic logic [15:0] pool_addr();
      logic [15:0] pool [8] = '{16'h0000, 16'hffff, 16'h00ff, 16'h0100, 16'h1234,
                                16'h5a42, 16'h8000, 16'h0042};
      logic [7:0] hi;
      hi = ($urandom_range(255) == 0) ? 8'h00 : 8'($urandom);
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return {hi, pool[3'($urandom_range(7))][7:0]};
         default: return pool[3'($urandom_range(7))];
      endcase
   endfunction

   task automatic queue_random(int count);
      debug_event_type e;
      for (int i = 0; i < count; i++) begin
         e = make_event(bwu_pkg::opcode_type'(3'($urandom_range(7))), pool_addr());
         case ($urandom_range(9))
            0, 1: e.opcode = bwu_pkg::OP_TOGGLE;
            2, 3, 4: e.opcode = bwu_pkg::OP_BOUNDARY;
            default: ;
         endcase
         if (e.opcode == bwu_pkg::OP_SET_STEP && $urandom_range(1))
            e.step_count = 16'($urandom_range(4));
         e.halted = ($urandom_range(3) == 0);
         pending_events.push_back(e);
      end
   endtask

   task automatic wait_drained();
      while (pending_events.size() > 0 || expected_verdicts.size() > 0 || req_tvalid)
         @(posedge clock);
   endtask

   initial begin
      debug_event_type e;
      report_valid = 0;
      stop_pending = 0;
      steps_left = 0;
      for (int s = 0; s < 4; s++) list_len[s] = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: fill breakpoints to full, hit, halted skip, remove with move
      for (int i = 0; i < 17; i++) begin
         e = make_event(bwu_pkg::OP_TOGGLE, 16'(i * 16'h1111));
         e.list_select = bwu_pkg::LIST_BP;
         pending_events.push_back(e);
      end
      e = make_event(bwu_pkg::OP_BOUNDARY, 16'hffff); pending_events.push_back(e);
      e.halted = 1; pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_TOGGLE, 16'h0000); e.list_select = bwu_pkg::LIST_BP;
      pending_events.push_back(e);
      // short port watch, matched on the low byte of two io ports
      e = make_event(bwu_pkg::OP_TOGGLE, 16'h00ff); e.list_select = bwu_pkg::LIST_PW;
      pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_IO, 16'hab00 | 16'h00ff); e.io_out = 0;
      pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_IO, 16'h12ff); pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_STOP_REQ, 16'h0000); pending_events.push_back(e);
      pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_SET_STEP, 16'h0000); e.step_count = 0;
      pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_BOUNDARY, 16'h4321); pending_events.push_back(e);
      e = make_event(bwu_pkg::OP_UNUSED, 16'hffff); e.data = 8'hff; e.step_count = 16'hffff;
      e.halted = 1; e.io_out = 1; pending_events.push_back(e);

      send_idle_pct = 7; recv_idle_pct = 86;
      queue_random(500);
      wait_drained();
      // hold the sender idle once every result is back
      hold_send = 1;
      repeat (3) @(posedge clock);
      hold_send = 0;
      send_idle_pct = 86; recv_idle_pct = 7;
      queue_random(550);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(575);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("checked %0d results, %0d of them stops, over four lists and all opcodes",
               verdicts_seen, stops_seen);
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
